@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL files that include them.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CDSO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdso assertion failed");

// Next-cycle implication.
`define CDSO_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdso assertion failed");

`endif

@@ hdl/cdso_pkg.sv @@
package cdso_pkg;

    localparam int MAX_ENTRIES = 128;
    localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = ENTRY_AW + 1;

    // Function codes
    localparam logic FUNC_WRITE     = 1'b0;
    localparam logic FUNC_TRANSLATE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_RAW    = 2'd2;
    localparam logic [1:0] ST_WRITTEN   = 2'd3;

    // Sector size codes
    localparam logic [1:0] SZ_2048 = 2'd0;
    localparam logic [1:0] SZ_2336 = 2'd1;
    localparam logic [1:0] SZ_2352 = 2'd2;
    localparam logic [1:0] SZ_2448 = 2'd3;

    localparam logic [11:0] RAW_BYTES         = 12'd2352;
    localparam logic [11:0] COOKED_BYTES      = 12'd2048;
    localparam logic [4:0]  RAW_HEADER_SKIP   = 5'd16;
    localparam logic [4:0]  MODE2_HEADER_SKIP = 5'd24;

    typedef struct packed {
        logic        func;
        logic [6:0]  entry_index;
        logic [19:0] entry_start;
        logic [31:0] entry_skip;
        logic [1:0]  entry_size_code;
        logic        entry_mode2;
        logic        entry_is_data;
        logic [19:0] sector;
        logic        raw;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  track_number;
        logic [31:0] byte_offset;
        logic [11:0] read_length;
        logic        data_track;
    } out_item_t;

    // One track table entry
    typedef struct packed {
        logic [19:0] start;
        logic [31:0] skip;
        logic [1:0]  size_code;
        logic        mode2;
        logic        is_data;
    } entry_t;

    function automatic logic [11:0] size_bytes(input logic [1:0] code);
        logic [11:0] r;
        case (code)
            SZ_2048: r = 12'd2048;
            SZ_2336: r = 12'd2336;
            SZ_2352: r = 12'd2352;
            SZ_2448: r = 12'd2448;
            default: r = 12'd2048;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/cd_sector_to_image_offset.sv @@
// Track table lookup: a write item loads one table entry; a translate item
// walks the entries in use (track_count, clamped to 128) one per cycle through
// the single read port of the track memory and, on a hit, then passes through
// the multiply-add offset unit. A translate with fewer than two entries in use
// is answered not found without a walk; neither a miss nor a raw request
// refused on a hit goes through the offset unit. The input is stalled from
// the take until the result moves into the output register, so no new item
// is taken before the last one is through. A finished result sits in the
// output register, and the next item is taken while it waits.
module cd_sector_to_image_offset (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cdso_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output cdso_pkg::out_item_t out_item,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);
    import cdso_pkg::*;
    `include "assert_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [7:0]         track_count_reg;
    logic [COUNT_W-1:0] used;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               have_prev_reg, have_prev_next;
    entry_t             prev_reg, prev_next;
    logic [19:0]        sector_reg;
    logic               raw_reg;
    logic [6:0]         num_reg, num_next;
    out_item_t          res_reg, res_next;
    out_item_t          out_item_reg;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic               out_free;
    logic               hit;
    logic               off_start;
    logic               off_done;
    logic [31:0]        off_value;
    logic               rd_en;
    logic [ENTRY_AW-1:0] rd_addr;
    entry_t             rd_data;
    entry_t             wr_data;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Count register, stored as written; clamped to table depth in used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_count_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            track_count_reg <= cfg_wr_data;
        end
    end

    assign used = (track_count_reg > 8'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES)
                                                      : COUNT_W'(track_count_reg);

    // Track memory
    assign wr_data = '{start:     in_item.entry_start,
                       skip:      in_item.entry_skip,
                       size_code: in_item.entry_size_code,
                       mode2:     in_item.entry_mode2,
                       is_data:   in_item.entry_is_data};
    assign rd_en   = (accept && in_item.func == FUNC_TRANSLATE) || state_reg == S_WALK;
    assign rd_addr = (state_reg == S_IDLE) ? '0 : idx_reg[ENTRY_AW-1:0];

    cdso_table u_table (
        .clk     (clk),
        .wr_en   (accept && in_item.func == FUNC_WRITE),
        .wr_addr (in_item.entry_index[ENTRY_AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Offset multiply-add unit
    cdso_offset u_offset (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (off_start),
        .entry  (prev_reg),
        .sector (sector_reg),
        .raw    (raw_reg),
        .done   (off_done),
        .offset (off_value)
    );

    // Previous entry holds the candidate, current read is its successor
    assign hit = (prev_reg.start <= sector_reg) && (sector_reg < rd_data.start);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        num_next       = num_reg;
        res_next       = res_reg;
        off_start      = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next       = COUNT_W'(1);
                    have_prev_next = 1'b0;
                    if (in_item.func == FUNC_WRITE)
                    begin
                        res_next   = '{status: ST_WRITTEN, default: '0};
                        state_next = S_DONE;
                    end
                    else if (used < COUNT_W'(2))
                    begin
                        res_next   = '{status: ST_NOT_FOUND, default: '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (!have_prev_reg)
                begin
                    prev_next      = rd_data;
                    have_prev_next = 1'b1;
                    idx_next       = idx_reg + COUNT_W'(1);
                end
                else if (hit)
                begin
                    num_next = 7'(idx_reg - COUNT_W'(1));
                    if (raw_reg && prev_reg.size_code != SZ_2352)
                    begin
                        res_next = '{status:       ST_NO_RAW,
                                     track_number: 7'(idx_reg - COUNT_W'(1)),
                                     byte_offset:  32'd0,
                                     read_length:  12'd0,
                                     data_track:   prev_reg.is_data};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        off_start  = 1'b1;
                        state_next = S_CALC;
                    end
                end
                else if (idx_reg == used)
                begin
                    res_next   = '{status: ST_NOT_FOUND, default: '0};
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next = rd_data;
                    idx_next  = idx_reg + COUNT_W'(1);
                end
            end
            S_CALC:
            begin
                if (off_done)
                begin
                    res_next = '{status:       ST_OK,
                                 track_number: num_reg,
                                 byte_offset:  off_value,
                                 read_length:  raw_reg ? RAW_BYTES : COOKED_BYTES,
                                 data_track:   prev_reg.is_data};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        num_reg  <= num_next;
        res_reg  <= res_next;
        if (accept)
        begin
            sector_reg <= in_item.sector;
            raw_reg    <= in_item.raw;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_item_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Walk never runs past the entries in use
    `CDSO_ASSERT_IMP(a_walk_bound, state_reg == S_WALK, idx_reg <= used && idx_reg != '0)
    // Offset unit finishes only while the sequencer waits for it
    `CDSO_ASSERT_IMP(a_off_done_calc, off_done, state_reg == S_CALC)
    // A good translate names a real track
    `CDSO_ASSERT_IMP(a_ok_track, out_valid_reg && out_item_reg.status == ST_OK,
                     out_item_reg.track_number != 7'd0)
    // Offset start leads to the calc state
    `CDSO_ASSERT_NXT(a_start_calc, off_start, state_reg == S_CALC)

endmodule

@@ hdl/cdso_table.sv @@
module cdso_table (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [cdso_pkg::ENTRY_AW-1:0] wr_addr,
    input  cdso_pkg::entry_t              wr_data,
    input  logic                          rd_en,
    input  logic [cdso_pkg::ENTRY_AW-1:0] rd_addr,
    output cdso_pkg::entry_t              rd_data
);
    import cdso_pkg::*;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/cdso_offset.sv @@
module cdso_offset (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cdso_pkg::entry_t  entry,
    input  logic [19:0]       sector,
    input  logic              raw,
    output logic              done,
    output logic [31:0]       offset
);
    import cdso_pkg::*;

    logic [19:0] diff;
    logic [4:0]  adj;
    logic [31:0] prod_reg;
    logic [31:0] base_reg;
    logic [31:0] offset_reg;
    logic        stage1_reg;
    logic        done_reg;

    // Sectors into the track and cooked-read header skip
    always_comb
    begin
        diff = sector - entry.start;
        adj  = 5'd0;
        if (!raw)
        begin
            if (entry.mode2)
            begin
                adj = MODE2_HEADER_SKIP;
            end
            else if (entry.size_code == SZ_2352 || entry.size_code == SZ_2448)
            begin
                adj = RAW_HEADER_SKIP;
            end
        end
    end

    // Stage 1: multiply, stage 2: add
    always_ff @(posedge clk)
    begin
        prod_reg   <= 32'(diff) * 32'(size_bytes(entry.size_code));
        base_reg   <= entry.skip + 32'(adj);
        offset_reg <= prod_reg + base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            done_reg   <= stage1_reg;
        end
    end

    assign done   = done_reg;
    assign offset = offset_reg;

endmodule

@@ bench/cd_sector_to_image_offset_checker.sv @@
`timescale 1ns / 100ps

// Watches both item channels and the track_count port, keeps its own copy of
// the track table and checks every result against the expected one, in order.
module cd_sector_to_image_offset_checker
    import cdso_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_item_t   in_item,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_item_t  out_item,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output int         fail_count,
    output int         pending,
    output int         checked_count
);

    localparam int REPORT_LIMIT = 10;

    // Shadow of the track table and the register
    entry_t      track_tab [MAX_ENTRIES];
    logic [7:0]  track_cnt;

    out_item_t   expected_q [$];
    out_item_t   want;
    int          fails;
    int          checked;

    // Expected result of a lookup against the current shadow table
    function automatic out_item_t lookup_result(input in_item_t it);
        out_item_t   res;
        int          span;
        int          hit;
        int          i;
        bit          found;
        entry_t      e;
        logic [31:0] bytes_per;
        res = '0;
        span = (track_cnt > MAX_ENTRIES) ? MAX_ENTRIES : int'(track_cnt);
        found = 1'b0;
        hit = 0;
        for (i = 0; i + 1 < span; i++)
        begin
            if (!found && track_tab[i].start <= it.sector &&
                it.sector < track_tab[i + 1].start)
            begin
                found = 1'b1;
                hit = i;
            end
        end
        if (!found)
        begin
            res.status = ST_NOT_FOUND;
            return res;
        end
        e = track_tab[hit];
        res.track_number = 7'(hit + 1);
        res.data_track = e.is_data;
        // raw reads only exist on 2352-byte tracks
        if (it.raw && e.size_code != SZ_2352)
        begin
            res.status = ST_NO_RAW;
            return res;
        end
        case (e.size_code)
            SZ_2048: bytes_per = 32'd2048;
            SZ_2336: bytes_per = 32'd2336;
            SZ_2352: bytes_per = 32'd2352;
            default: bytes_per = 32'd2448;
        endcase
        res.status = ST_OK;
        res.byte_offset = e.skip + (32'(it.sector) - 32'(e.start)) * bytes_per;
        // cooked reads skip the sector header
        if (!it.raw)
        begin
            if ((e.size_code == SZ_2352 || e.size_code == SZ_2448) && !e.mode2)
                res.byte_offset = res.byte_offset + 32'(RAW_HEADER_SKIP);
            if (e.mode2)
                res.byte_offset = res.byte_offset + 32'(MODE2_HEADER_SKIP);
        end
        res.read_length = it.raw ? RAW_BYTES : COOKED_BYTES;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            track_cnt = '0;
            fails = 0;
            checked = 0;
            fail_count <= 0;
            pending <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                track_cnt = cfg_wr_data;

            // result side: compare with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display({"[%0t] unexpected result: status %0d track %0d",
                                  " offset %h len %0d data %0d"},
                                 $realtime, out_item.status, out_item.track_number,
                                 out_item.byte_offset, out_item.read_length,
                                 out_item.data_track);
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked++;
                    if (out_item.status !== want.status ||
                        out_item.track_number !== want.track_number ||
                        out_item.byte_offset !== want.byte_offset ||
                        out_item.read_length !== want.read_length ||
                        out_item.data_track !== want.data_track)
                    begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display({"[%0t] result %0d: exp status %0d track %0d",
                                      " offset %h len %0d data %0d",
                                      " / got status %0d track %0d offset %h len %0d data %0d"},
                                     $realtime, checked, want.status, want.track_number,
                                     want.byte_offset, want.read_length, want.data_track,
                                     out_item.status, out_item.track_number,
                                     out_item.byte_offset, out_item.read_length,
                                     out_item.data_track);
                    end
                end
            end

            // item side: writes update the table, lookups predict a result
            if (in_valid && !in_stall)
            begin
                if (in_item.func == FUNC_WRITE)
                begin
                    track_tab[in_item.entry_index] = {in_item.entry_start, in_item.entry_skip,
                                                      in_item.entry_size_code,
                                                      in_item.entry_mode2,
                                                      in_item.entry_is_data};
                    want = '0;
                    want.status = ST_WRITTEN;
                end
                else
                    want = lookup_result(in_item);
                expected_q = {expected_q, want};
            end

            fail_count <= fails;
            pending <= expected_q.size();
            checked_count <= checked;
        end
    end

endmodule

@@ bench/cd_sector_to_image_offset_tb.sv @@
`timescale 1ns / 100ps

module cd_sector_to_image_offset_tb;
    import cdso_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 850;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_WAIT       = 160;
    localparam int LONG_HOLD      = 400;
    localparam int TIMEOUT_CYCLES = 1000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_item;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    int fail_count;
    int pending;
    int checked_count;

    // Stimulus bookkeeping
    logic [19:0] shadow_start [MAX_ENTRIES];
    int unsigned items_sent = 0;
    int unsigned write_items = 0;
    int unsigned lookup_items = 0;
    int unsigned setups = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    cd_sector_to_image_offset dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    cd_sector_to_image_offset_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // Item with every field random; callers override what matters
    function automatic in_item_t random_item();
        in_item_t it;
        it.func            = 1'($urandom);
        it.entry_index     = 7'($urandom);
        it.entry_start     = 20'($urandom);
        it.entry_skip      = $urandom;
        it.entry_size_code = 2'($urandom);
        it.entry_mode2     = 1'($urandom);
        it.entry_is_data   = 1'($urandom);
        it.sector          = 20'($urandom);
        it.raw             = 1'($urandom);
        return it;
    endfunction

    // Offer one item, with an occasional idle burst first; returns once taken
    task automatic push_item(input in_item_t it);
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (it.func == FUNC_WRITE)
            write_items++;
        else
            lookup_items++;
    endtask

    task automatic entry_write(input logic [6:0] idx, input logic [19:0] start,
                               input logic [31:0] skip, input logic [1:0] code,
                               input logic m2, input logic data);
        in_item_t it;
        it = random_item();
        it.func            = FUNC_WRITE;
        it.entry_index     = idx;
        it.entry_start     = start;
        it.entry_skip      = skip;
        it.entry_size_code = code;
        it.entry_mode2     = m2;
        it.entry_is_data   = data;
        shadow_start[idx]  = start;
        push_item(it);
    endtask

    task automatic load_entry(input logic [6:0] idx, input logic [19:0] start);
        entry_write(idx, start, $urandom, 2'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic lookup(input logic [19:0] sector, input logic raw);
        in_item_t it;
        it = random_item();
        it.func   = FUNC_TRANSLATE;
        it.sector = sector;
        it.raw    = raw;
        push_item(it);
    endtask

    // Stop offering and wait for every result, then for the given quiet cycles
    task automatic settle(input int cycles);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic set_track_count(input logic [7:0] n);
        settle(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        setups++;
    endtask

    // Sector aimed mostly inside a track, at its edges, or just outside the table
    function automatic logic [19:0] aim_sector(input int unsigned eff);
        int unsigned j;
        logic [19:0] lo;
        logic [19:0] hi;
        logic [19:0] s;
        s = 20'($urandom);
        if (eff >= 2 && $urandom_range(0, 9) < 8)
        begin
            j = $urandom_range(0, eff - 2);
            lo = shadow_start[j];
            hi = shadow_start[j + 1];
            if (hi > lo)
            begin
                case ($urandom_range(0, 3))
                    0: s = lo;
                    1: s = hi - 20'd1;
                    default: s = lo + 20'($urandom_range(0, hi - lo - 1));
                endcase
            end
            else
                s = lo;
        end
        else if (eff >= 1)
        begin
            case ($urandom_range(0, 2))
                0: s = shadow_start[eff - 1];
                1: s = shadow_start[0] - 20'd1;
                default: ;
            endcase
        end
        return s;
    endfunction

    // Load entries 0..eff-1, ascending starts unless a scrambled table is asked
    task automatic build_table(input int unsigned eff, input bit in_order);
        logic [19:0] stride_max;
        logic [19:0] pos;
        int unsigned i;
        stride_max = ($urandom_range(0, 4) == 0) ? 20'd1 : 20'($urandom_range(1, 8000));
        pos = 20'($urandom_range(0, 20'hFFFFF - eff * stride_max));
        for (i = 0; i < eff; i++)
        begin
            if (in_order)
            begin
                load_entry(7'(i), pos);
                pos = pos + 20'($urandom_range(1, stride_max));
            end
            else
                load_entry(7'(i), 20'($urandom));
        end
    endtask

    // Lookups with a sprinkling of entry rewrites
    task automatic run_lookups(input int unsigned count_items, input int unsigned eff);
        int unsigned k;
        logic [6:0]  idx;
        for (k = 0; k < count_items; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                idx = 7'($urandom);
                load_entry(idx, $urandom_range(0, 1) ? shadow_start[idx] : 20'($urandom));
            end
            else
                lookup(aim_sector(eff), 1'($urandom));
        end
    endtask

    // Receiver: random stall bursts, quiet stretches, and one long hold-off
    always
    begin
        @(posedge clk);
        if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            out_stall <= 1'b0;
            hold_done = 1'b1;
        end
        else if (sink_idle_on && $urandom_range(0, 39) == 0)
            repeat ($urandom_range(50, 150)) @(posedge clk);
        else if (sink_idle_on && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("cd_sector_to_image_offset: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned directed_items;
        int unsigned n;
        int unsigned eff;
        int unsigned ph;
        bit          quiet_tail;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table after reset
        lookup(20'd0, 1'b0);

        // one track of each size code, a wrapping skip, lead-out at the top sector
        entry_write(7'd0, 20'd0,     32'hFFFF_FFF0, SZ_2448, 1'b0, 1'b1);
        entry_write(7'd1, 20'd10,    32'h0000_0000, SZ_2352, 1'b0, 1'b0);
        entry_write(7'd2, 20'd20,    32'h0010_0000, SZ_2352, 1'b1, 1'b1);
        entry_write(7'd3, 20'd30,    32'h0000_0000, SZ_2048, 1'b0, 1'b1);
        entry_write(7'd4, 20'd40,    32'hFFFF_FFFF, SZ_2336, 1'b1, 1'b0);
        entry_write(7'd5, 20'hFFFFF, 32'h0000_0000, SZ_2048, 1'b0, 1'b0);

        // a lone entry is only the lead-out
        set_track_count(8'd1);
        lookup(20'd0, 1'b0);

        set_track_count(8'd6);
        lookup(20'd0, 1'b0);       // 2448 cooked, header skip wraps to zero
        lookup(20'd9, 1'b1);       // raw on a 2448 track
        lookup(20'd9, 1'b0);
        lookup(20'd10, 1'b1);      // raw on 2352
        lookup(20'd19, 1'b0);      // cooked 2352, plus 16
        lookup(20'd20, 1'b0);      // cooked mode 2, plus 24
        lookup(20'd25, 1'b1);      // raw mode 2
        lookup(20'd30, 1'b1);      // raw on 2048
        lookup(20'd39, 1'b0);      // cooked 2048, no skip
        lookup(20'd40, 1'b0);      // mode 2 on 2336 with skip at the top
        lookup(20'hFFFFE, 1'b0);   // large distance, offset wraps
        lookup(20'hFFFFE, 1'b1);   // raw on 2336
        lookup(20'hFFFFF, 1'b0);   // lead-out sector itself
        directed_items = items_sent;

        // random table setups, each followed by a run of lookups
        ph = 0;
        while (items_sent - directed_items < RANDOM_ITEMS)
        begin
            quiet_tail   = (items_sent - directed_items) > RANDOM_ITEMS * 4 / 5;
            src_idle_on  = !quiet_tail && ($urandom_range(0, 3) != 0);
            sink_idle_on = !quiet_tail && ($urandom_range(0, 3) != 0);
            case (ph)
                1:
                begin
                    n = MAX_ENTRIES;
                    build_table(n, 1'b1);
                end
                2: n = 255;                // above the table size, full table reused
                3: n = MAX_ENTRIES + 1;
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: n = $urandom_range(0, 1);
                        1: n = $urandom_range(17, 48);
                        default: n = $urandom_range(2, 16);
                    endcase
                    build_table(n, $urandom_range(0, 5) != 0);
                end
            endcase
            eff = (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
            set_track_count(8'(n));
            if (ph == 4)
                hold_req = 1'b1;
            run_lookups((eff > 16) ? $urandom_range(12, 24) : $urandom_range(30, 60), eff);
            ph++;
        end

        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        settle(END_WAIT);

        $display("Drove %0d items (%0d entry writes, %0d lookups) over %0d table setups,",
                 items_sent, write_items, lookup_items, setups);
        $display("track_count from 0 to 255, %0d results compared, %0d failures.",
                 checked_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("cd_sector_to_image_offset: match");
        else
            $display("cd_sector_to_image_offset: mismatch");
        $finish;
    end

endmodule
